[sv/delimiter_string_tokenizer_defines.svh]
// Assertion macros shared by the delimiter string tokenizer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef DELIMITER_STRING_TOKENIZER_DEFINES_SVH
`define DELIMITER_STRING_TOKENIZER_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define DST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define DST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/dst_pkg.sv]
// Shared types and constants for the delimiter string tokenizer.
// No dependencies; imported by every module of the block.
package dst_pkg;

   localparam int DLEN_W     = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 64;
   localparam int START_W    = 16;
   localparam int LENGTH_W   = 17;
   localparam int RSP_DATA_W = 40;

   localparam logic [CSR_IDX_W-1:0] CSR_DELIM_BYTES  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELIM_LENGTH = 1'b1;

   typedef enum logic [1:0] {
      KIND_FIELD = 2'd0,
      KIND_END   = 2'd1,
      KIND_SHORT = 2'd2,
      KIND_LONG  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [START_W-1:0]  start;
      logic [LENGTH_W-1:0] length;
      kind_type            kind;
      logic                eos;
   } rsp_type;

   // control from the field tracker to the match window
   typedef struct packed {
      logic shift;
      logic clear;
      logic seen_ok;
   } win_ctl_type;

endpackage

[sv/dst_window.sv]
// Byte window and delimiter compare for the tokenizer.
// Depends on dst_pkg; drives the match flag consumed by dst_tracker.
module dst_window #(
   parameter int MAX_DELIMITER_BYTES = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  dst_pkg::win_ctl_type             ctl,
   input  logic [7:0]                       byte_value,
   input  logic [8*MAX_DELIMITER_BYTES-1:0] delimiter,
   input  logic [dst_pkg::DLEN_W-1:0]       dlen,
   output logic                             matched
);
   import dst_pkg::*;

   localparam int MAXD  = MAX_DELIMITER_BYTES;
   localparam int IW    = (MAXD > 1) ? $clog2(MAXD) : 1;
   localparam int SW    = $clog2(MAXD + 1);
   localparam int CMP_W = DLEN_W + 1;

   logic [MAXD-1:0][7:0] window_ff;
   logic [MAXD-1:0][7:0] window_in;
   logic [SW-1:0]        since_ff;
   logic [SW-1:0]        since_in;
   logic [SW:0]          since_inc;
   logic                 since_ge;
   logic                 all_eq;

   // window_in[0] is the newest byte, entry j is the byte j beats back
   always_comb begin
      window_in[0] = byte_value;
      for (int j = 1; j < MAXD; j++) begin
         window_in[j] = window_ff[j-1];
      end
   end

   // delimiter byte k lines up with the byte (dlen-1-k) beats back
   always_comb begin
      logic [DLEN_W-1:0] idx;
      all_eq = 1'b1;
      for (int k = 0; k < MAXD; k++) begin
         idx = dlen - DLEN_W'(1) - DLEN_W'(k);
         if ((DLEN_W'(k) < dlen) && (delimiter[8*k +: 8] != window_in[idx[IW-1:0]])) begin
            all_eq = 1'b0;
         end
      end
   end

   assign since_inc = {1'b0, since_ff} + (SW+1)'(1);
   assign since_ge  = CMP_W'(since_inc) >= CMP_W'(dlen);
   assign matched   = (dlen != '0) && ctl.seen_ok && since_ge && all_eq;

   always_comb begin
      since_in = since_ff;
      if (ctl.clear) begin
         since_in = SW'(MAXD);
      end else if (ctl.shift) begin
         if (matched) begin
            since_in = '0;
         end else if (since_inc > (SW+1)'(MAXD)) begin
            since_in = SW'(MAXD);
         end else begin
            since_in = since_inc[SW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         since_ff <= SW'(MAXD);
      end else begin
         since_ff <= since_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         window_ff <= window_in;
      end
   end

endmodule

[sv/dst_tracker.sv]
// Byte count, field anchor and overflow tracking; forms each result.
// Depends on dst_pkg; pairs with dst_window for the match flag.
module dst_tracker #(
   parameter longint unsigned MAX_STRING_BYTES = 65536
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       last,
   input  logic [dst_pkg::DLEN_W-1:0] dlen,
   input  logic                       matched,
   output dst_pkg::win_ctl_type       ctl,
   output logic                       res_valid,
   output dst_pkg::rsp_type           res
);
   import dst_pkg::*;

   localparam int CW = $clog2(MAX_STRING_BYTES + 1);
   localparam int OW = (CW > LENGTH_W) ? CW : LENGTH_W;

   logic [CW-1:0] seen_ff,   seen_in;
   logic [CW-1:0] anchor_ff, anchor_in;
   logic          ovf_ff,    ovf_in;
   logic          ovf_now;
   logic [CW-1:0] seen_new;
   logic [CW-1:0] mstart;
   logic          hit;
   logic          too_short;
   logic [OW-1:0] start_ext;
   logic [OW-1:0] len_ext;

   assign ovf_now   = ovf_ff || (seen_ff >= CW'(MAX_STRING_BYTES));
   assign seen_new  = seen_ff + CW'(1);
   assign mstart    = seen_new - CW'(dlen);
   assign hit       = matched && !ovf_now;
   assign too_short = (dlen == '0) || (seen_new <= CW'(dlen));

   assign ctl.shift   = advance && !ovf_now;
   assign ctl.clear   = advance && last;
   assign ctl.seen_ok = seen_new >= CW'(dlen);

   assign start_ext = OW'(anchor_ff);

   always_comb begin
      res_valid = 1'b0;
      res.kind  = KIND_FIELD;
      res.eos   = last;
      len_ext   = '0;
      if (last) begin
         res_valid = 1'b1;
         if (ovf_now) begin
            res.kind = KIND_LONG;
         end else if (too_short) begin
            res.kind = KIND_SHORT;
         end else if (hit) begin
            if (mstart > anchor_ff) begin
               len_ext = OW'(mstart - anchor_ff);
            end else begin
               res.kind = KIND_END;
            end
         end else begin
            len_ext = OW'(seen_new - anchor_ff);
         end
      end else if (hit && (mstart > anchor_ff)) begin
         res_valid = 1'b1;
         len_ext   = OW'(mstart - anchor_ff);
      end
      res.start  = (res.kind == KIND_FIELD) ? start_ext[START_W-1:0] : '0;
      res.length = len_ext[LENGTH_W-1:0];
   end

   always_comb begin
      seen_in   = seen_ff;
      anchor_in = anchor_ff;
      ovf_in    = ovf_ff;
      if (advance) begin
         if (last) begin
            seen_in   = '0;
            anchor_in = '0;
            ovf_in    = 1'b0;
         end else if (ovf_now) begin
            ovf_in = 1'b1;
         end else begin
            seen_in = seen_new;
            if (hit) begin
               anchor_in = seen_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff   <= '0;
         anchor_ff <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         seen_ff   <= seen_in;
         anchor_ff <= anchor_in;
         ovf_ff    <= ovf_in;
      end
   end

endmodule

[sv/delimiter_string_tokenizer.sv]
// Top level of the delimiter string tokenizer: input stage, settings, result register.
// Depends on dst_pkg, dst_window, dst_tracker and the assertion macro header.
//
// Usage:
//   req_ carries one string byte per beat; req_tlast marks the final byte.
//   rsp_ carries at most one result per input byte: a field (start offset and
//   length) when a delimiter match completes with a non-empty field before it,
//   and always one result on the final byte (remainder field, end without
//   field, rejected too short, or string too long), tagged by rsp_tlast.
//   csr_ writes the delimiter bytes (index 0) and delimiter length (index 1);
//   write only while no string is in flight.
// Timing:
//   A byte lands in the input register, is matched and tracked combinationally
//   from there, and its result is loaded into the output register that drives
//   rsp_tvalid. One byte per cycle is sustained while the result slot is free or
//   draining, set by the single window compare and tracker update per beat.
// Reset: synchronous; clears both stages and the string state, and loads the
//   delimiter ',' with length 1.
// Stall: while rsp_tready is low and a result waits, the input register holds
//   its byte and req_tready drops once that register is full.
module delimiter_string_tokenizer #(
   parameter longint unsigned MAX_STRING_BYTES    = 65536,
   parameter int              MAX_DELIMITER_BYTES = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: byte_value [7:0]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,
   input  logic                                req_tlast,
   // rsp_tdata: field_start [15:0], field_length [32:16], zero pad [39:33]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dst_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // rsp_tuser: result_kind [1:0]
   output logic [1:0]                          rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [dst_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dst_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import dst_pkg::*;

   `include "delimiter_string_tokenizer_defines.svh"

   localparam int MAXD = MAX_DELIMITER_BYTES;
   localparam int DW   = 8 * MAXD;

   logic [DW-1:0]     delim_ff, delim_in;
   logic [DLEN_W-1:0] dlen_ff,  dlen_in;
   logic [DLEN_W-1:0] dlen_eff;

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_byte_ff;
   logic              in_last_ff;
   logic              req_take;
   logic              advance;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff;

   win_ctl_type       win_ctl;
   logic              matched;
   logic              res_valid;
   rsp_type           res;

   // settings
   always_comb begin
      delim_in = delim_ff;
      dlen_in  = dlen_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DELIM_BYTES:  delim_in = csr_wdata[DW-1:0];
            CSR_DELIM_LENGTH: dlen_in  = csr_wdata[DLEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= DW'(64'd44);
         dlen_ff  <= DLEN_W'(1);
      end else begin
         delim_ff <= delim_in;
         dlen_ff  <= dlen_in;
      end
   end

   assign dlen_eff = (dlen_ff > DLEN_W'(MAXD)) ? DLEN_W'(MAXD) : dlen_ff;

   // input stage: advance when the result slot is free or draining
   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign req_take    = req_tvalid && req_tready;
   assign in_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   dst_window #(
      .MAX_DELIMITER_BYTES(MAX_DELIMITER_BYTES)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .ctl        (win_ctl),
      .byte_value (in_byte_ff),
      .delimiter  (delim_ff),
      .dlen       (dlen_eff),
      .matched    (matched)
   );

   dst_tracker #(
      .MAX_STRING_BYTES(MAX_STRING_BYTES)
   ) u_tracker (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .last      (in_last_ff),
      .dlen      (dlen_eff),
      .matched   (matched),
      .ctl       (win_ctl),
      .res_valid (res_valid),
      .res       (res)
   );

   // result register: load a new beat, drop it once taken
   assign rsp_valid_in = (advance && res_valid) ? 1'b1 :
                         (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_ff.length, rsp_ff.start});
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.eos;

   `DST_ASSERT_NEXT(a_last_gives_result, clock, reset,
      advance && in_last_ff, rsp_valid_ff && rsp_ff.eos,
      "final byte left no end-of-string result")
   `DST_ASSERT_NOW(a_mid_result_is_field, clock, reset,
      rsp_valid_ff && !rsp_ff.eos, rsp_ff.kind == KIND_FIELD,
      "result before the final byte is not a field")
   `DST_ASSERT_NOW(a_nonfield_is_zero, clock, reset,
      rsp_valid_ff && (rsp_ff.kind != KIND_FIELD), rsp_tdata == '0,
      "non-field result carries a start or length")
   `DST_ASSERT_NOW(a_field_not_empty, clock, reset,
      rsp_valid_ff && (rsp_ff.kind == KIND_FIELD) && (MAX_STRING_BYTES <= 65536),
      rsp_ff.length != '0,
      "field result with zero length")

endmodule

[bench/tb_delimiter_string_tokenizer.sv]
// Self-checking bench for delimiter_string_tokenizer: drives byte strings and CSR writes,
// predicts every result in a scoreboard class and checks each response beat.
// Depends on dst_pkg and the delimiter_string_tokenizer RTL only.
`timescale 1ns / 1ps

module tb_delimiter_string_tokenizer;
   import dst_pkg::*;

   typedef logic [7:0] byte_q[$];

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 6;
   localparam int RANDOM_ITEMS   = 1800;

   class field_scoreboard;
      logic [63:0]  delim = 64'd44;
      logic [3:0]   dlen  = 4'd1;
      logic [63:0]  window;
      int unsigned  seen, anchor, gap;
      bit           overflow;
      int unsigned  string_limit = 65536;
      rsp_type      due[$];
      int           errors;

      function void clear_string();
         window   = '0;
         seen     = 0;
         anchor   = 0;
         gap      = 8;
         overflow = 1'b0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [63:0] val);
         if (idx == CSR_DELIM_BYTES) delim = val;
         else if (idx == CSR_DELIM_LENGTH) dlen = val[3:0];
      endfunction

      function int pending();
         return due.size();
      endfunction

      function void queue_result(logic [31:0] start, logic [31:0] length, kind_type kind,
                                 logic eos);
         rsp_type r;
         r.start  = start[15:0];
         r.length = length[16:0];
         r.kind   = kind;
         r.eos    = eos;
         due.push_back(r);
      endfunction

      // Predict the result (if any) of one accepted byte.
      function void note_byte(logic [7:0] b, logic last);
         int unsigned dl, pos, since, mstart;
         bit          hit;
         logic [63:0] win, mask;
         dl     = (dlen > 8) ? 8 : dlen;
         pos    = seen;
         hit    = 1'b0;
         mstart = 0;
         if (!overflow && pos >= string_limit) overflow = 1'b1;
         if (!overflow) begin
            since  = gap + 1;
            window = {b, window[63:8]};
            seen   = pos + 1;
            // a match may not overlap the previous one
            if (dl != 0 && seen >= dl && since >= dl) begin
               win  = window >> (8 * (8 - dl));
               mask = (dl >= 8) ? '1 : ((64'd1 << (8 * dl)) - 64'd1);
               if (win == (delim & mask)) begin
                  hit    = 1'b1;
                  mstart = pos + 1 - dl;
               end
            end
            gap = hit ? 0 : ((since > 8) ? 8 : since);
         end
         if (last) begin
            if (overflow) queue_result(0, 0, KIND_LONG, 1'b1);
            else if (dl == 0 || seen <= dl) queue_result(0, 0, KIND_SHORT, 1'b1);
            else if (hit) begin
               if (mstart > anchor) queue_result(anchor, mstart - anchor, KIND_FIELD, 1'b1);
               else queue_result(0, 0, KIND_END, 1'b1);
            end else begin
               queue_result(anchor, seen - anchor, KIND_FIELD, 1'b1);
            end
            clear_string();
         end else if (hit) begin
            if (mstart > anchor) queue_result(anchor, mstart - anchor, KIND_FIELD, 1'b0);
            anchor = pos + 1;
         end
      endfunction

      task report(string msg);
         $display("MISMATCH %s", msg);
         errors++;
      endtask

      task check_field(logic [15:0] start, logic [16:0] length, logic [1:0] kind, logic eos);
         rsp_type want;
         if (due.size() == 0) begin
            report($sformatf("unexpected result start %0d length %0d kind %0d eos %0b",
                             start, length, kind, eos));
            return;
         end
         want = due.pop_front();
         if (start !== want.start)
            report($sformatf("field_start got %0d want %0d", start, want.start));
         if (length !== want.length)
            report($sformatf("field_length got %0d want %0d", length, want.length));
         if (kind !== want.kind)
            report($sformatf("result_kind got %0d want %s", kind, want.kind.name()));
         if (eos !== want.eos)
            report($sformatf("end_of_string got %0b want %0b", eos, want.eos));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   field_scoreboard sb;
   int              src_idle_pct;
   int              sink_stall_pct;
   int              items_sent;
   int              quiet_cycles;
   logic [63:0]     cur_delim;
   logic [3:0]      cur_dlen;

   delimiter_string_tokenizer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= sink_stall_pct);
   end

   // Predict on every accepted request beat, check every accepted response beat.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (req_tvalid && req_tready) sb.note_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready)
            sb.check_field(rsp_tdata[15:0], rsp_tdata[32:16], rsp_tuser, rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic set_idling(input int mode);
      case (mode)
         0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
         1: begin src_idle_pct = 70; sink_stall_pct = 0;  end
         2: begin src_idle_pct = 0;  sink_stall_pct = 70; end
         default: begin src_idle_pct = 24; sink_stall_pct = 24; end
      endcase
   endtask

   // Called at a falling edge; returns at the falling edge after the beat is taken,
   // with tvalid still high so back-to-back beats carry no bubble.
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = b;
      req_tlast  = last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_string(input byte_q s);
      for (int i = 0; i < s.size(); i++) send_byte(s[i], i == s.size() - 1);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] val);
      wait_drained();
      // a byte that yields no result may still be in the pipe
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      sb.set_register(idx, val);
      if (idx == CSR_DELIM_BYTES) cur_delim = val;
      else cur_dlen = val[3:0];
   endtask

   // Random string of total length n, with one delimiter byte 0xFF at delim_at.
   task automatic send_run(input int n, input int delim_at);
      for (int i = 0; i < n; i++)
         send_byte((i == delim_at) ? 8'hFF : 8'($urandom_range(254)), i == n - 1);
      req_tvalid = 1'b0;
   endtask

   // Half random bytes, half bytes taken from the delimiter to provoke partial matches.
   function automatic logic [7:0] pick_byte(input int dl);
      if (dl == 0 || $urandom_range(1) == 0) return 8'($urandom_range(255));
      return cur_delim[8 * $urandom_range(dl - 1) +: 8];
   endfunction

   function automatic byte_q make_string();
      byte_q s;
      int    dl, mode, pieces, n, i;
      dl   = (cur_dlen > 8) ? 8 : cur_dlen;
      mode = $urandom_range(9);
      if (mode == 0) begin
         n = $urandom_range(1, 24);
         repeat (n) s.push_back(8'($urandom_range(255)));
      end else if (mode == 1) begin
         n = $urandom_range(1, dl + 1);
         repeat (n) s.push_back(pick_byte(dl));
      end else begin
         pieces = $urandom_range(1, 5);
         repeat (pieces) begin
            n = $urandom_range(0, 5);
            repeat (n) s.push_back(pick_byte(dl));
            if ($urandom_range(9) < 8) begin
               for (i = 0; i < dl; i++) s.push_back(cur_delim[8 * i +: 8]);
            end else if (dl > 1) begin
               // broken delimiter: a proper prefix only
               n = $urandom_range(1, dl - 1);
               for (i = 0; i < n; i++) s.push_back(cur_delim[8 * i +: 8]);
            end
         end
         if ($urandom_range(1)) begin
            n = $urandom_range(1, 5);
            repeat (n) s.push_back(pick_byte(dl));
         end
      end
      if (s.size() == 0) s.push_back(8'($urandom_range(255)));
      return s;
   endfunction

   task automatic configure_phase(input int phase);
      logic [63:0] delim_val;
      logic [3:0]  dlen_val;
      int          r;
      if (phase == 0) begin
         delim_val = '1;
         dlen_val  = 4'd8;
      end else if (phase == 1) begin
         delim_val = '0;
         dlen_val  = 4'd1;
      end else begin
         r = $urandom_range(19);
         if (r < 2) dlen_val = 4'd0;
         else if (r < 4) dlen_val = 4'($urandom_range(9, 15));
         else dlen_val = 4'($urandom_range(1, 8));
         if ($urandom_range(3) == 0) delim_val = {8{8'($urandom_range(255))}};
         else delim_val = {$urandom, $urandom};
      end
      write_reg(CSR_DELIM_BYTES, delim_val);
      // upper bits of the length write are don't-care
      write_reg(CSR_DELIM_LENGTH, {$urandom, 28'($urandom_range(0, 268435455)), dlen_val});
   endtask

   initial begin
      int    phase, random_start, phase_start;
      byte_q s;
      clock          = 1'b0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tlast      = 1'b0;
      rsp_tready     = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_DELIM_BYTES;
      csr_wdata      = '0;
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      items_sent     = 0;
      cur_delim      = 64'd44;
      cur_dlen       = 4'd1;
      sb             = new();
      sb.clear_string();
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Directed strings on the reset delimiter ','
      s = {8'h00, 8'h2C, 8'hFF};
      send_string(s);
      s = {8'h2C, 8'h2C};
      send_string(s);
      s = {8'h61};
      send_string(s);
      s = {8'h61, 8'h2C};
      send_string(s);
      s = {8'h2C, 8'h61, 8'h62, 8'h2C, 8'h2C, 8'h63};
      send_string(s);
      // zero-length delimiter rejects every string
      write_reg(CSR_DELIM_LENGTH, 64'd0);
      s = {8'h2C, 8'h61};
      send_string(s);
      // length 15 clamps to 8; all-ones delimiter
      write_reg(CSR_DELIM_BYTES, '1);
      write_reg(CSR_DELIM_LENGTH, '1);
      s = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_string(s);

      random_start = items_sent;
      phase = 0;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         configure_phase(phase);
         set_idling(phase % 4);
         phase_start = items_sent;
         while (items_sent - phase_start < 80) begin
            s = make_string();
            send_string(s);
            if ($urandom_range(15) == 0) wait_drained();
         end
         phase++;
      end

      // Long strings: maximum field length, last offset, and overflow
      write_reg(CSR_DELIM_BYTES, 64'hFF);
      write_reg(CSR_DELIM_LENGTH, 64'd1);
      set_idling(0);
      send_run(65536, -1);
      send_run(65536, 65534);
      send_run(65540, 65534);

      wait_drained();
      repeat (10) @(negedge clock);
      if (sb.errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

[sim.f]
+incdir+sv
sv/dst_pkg.sv
sv/dst_window.sv
sv/dst_tracker.sv
sv/delimiter_string_tokenizer.sv
bench/tb_delimiter_string_tokenizer.sv
